// ----- rtl/upc_pkg.sv -----
// Shared types, constants and character functions of the URL percent codec.
`timescale 1ns / 1ps

package upc_pkg;

    localparam logic [15:0] CHAR_PCT       = 16'h0025;
    localparam logic [15:0] CHAR_ZERO      = 16'h0030;
    localparam logic [15:0] HEX_ALPHA_BASE = 16'h0037;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] in_char;
        logic        in_last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        out_last;
    } out_item_t;

    typedef struct packed {
        logic        triple;
        logic [15:0] ch;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic is_reserved(input logic [15:0] ch);
        logic hit;
        hit = 1'b0;
        case (ch)
            16'h003C, 16'h003E, 16'h0023, 16'h0040, 16'h0022, 16'h0026, 16'h0025,
            16'h0024, 16'h003A, 16'h002C, 16'h003B, 16'h003F, 16'h003D, 16'h007B,
            16'h007D, 16'h007C, 16'h005E, 16'h007E, 16'h005B, 16'h005D, 16'h0027,
            16'h0060, 16'h005C, 16'h0020, 16'h000A, 16'h0009, 16'h000D: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [15:0] hex_digit_char(input logic [3:0] nib);
        logic [15:0] r;
        if (nib > 4'd9)
        begin
            r = {12'h000, nib} + HEX_ALPHA_BASE;
        end
        else
        begin
            r = {12'h000, nib} + CHAR_ZERO;
        end
        return r;
    endfunction

    function automatic logic [3:0] hex_value(input logic [15:0] ch);
        logic [3:0] v;
        if ((ch >= 16'h0041 && ch <= 16'h0046) || (ch >= 16'h0061 && ch <= 16'h0066))
        begin
            v = ch[3:0] + 4'd9;
        end
        else if (ch >= 16'h0030 && ch <= 16'h0039)
        begin
            v = ch[3:0];
        end
        else
        begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

// ----- rtl/url_percent_codec.sv -----
// Top level of the URL percent codec: front end, command queue and back end.
//
// Usage:
//   src_valid/src_stall/src_data carry one 16-bit character and a last flag per
//   transaction; dst_valid/dst_stall/dst_data carry one converted character.
//   cfg_write loads cfg_data into the mode bit: 0 encodes, 1 decodes. Write it
//   only while no transaction is in flight.
//   The first result passes through the command queue and the output register
//   before it is valid on dst.
//   Throughput: one input transaction per cycle while the queue has room; the
//   output moves one character per cycle while dst_stall is low, so an encoded
//   reserved character takes three output characters. A four-entry command
//   queue absorbs these bursts; src_stall rises only when the queue is full.
//   Non-last decode inputs that open an escape or give its first digit emit none.
//   Reset clears the mode to encode, the escape state, the queue and dst_valid.
//   A stalled valid output holds; the queue keeps filling until full.
`timescale 1ns / 1ps

module url_percent_codec
    import upc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic      cfg_data,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_data,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_data
);

    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;
    q_status_t q_stat;

    upc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    upc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    upc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    a_status_consistent : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("front end pushed into a full queue");

    a_push_fills : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && q_stat.empty) |=> !q_stat.empty)
        else $error("queue stayed empty after a push");

endmodule

// ----- rtl/upc_front.sv -----
// Front end: accepts characters, tracks escape state and issues output commands.
`timescale 1ns / 1ps

module upc_front
    import upc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic      cfg_data,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_data,
    input  q_status_t q_stat,
    output logic      push,
    output cmd_t      push_cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic       mode_reg;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] hn_reg;
    logic [3:0] hn_next;
    logic       emit;
    logic       accept;
    logic [3:0] hv;

    assign src_stall = q_stat.full;
    assign accept    = src_valid && !q_stat.full;
    assign push      = accept && emit;
    assign hv        = hex_value(src_data.in_char);

    always_comb
    begin
        phase_next      = PH_IDLE;
        hn_next         = 4'd0;
        emit            = 1'b1;
        push_cmd.triple = 1'b0;
        push_cmd.ch     = src_data.in_char;
        push_cmd.last   = src_data.in_last;
        if (!mode_reg)
        begin
            push_cmd.triple = is_reserved(src_data.in_char);
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    if (src_data.in_last)
                    begin
                        push_cmd.ch   = {8'h00, hv, 4'h0};
                        push_cmd.last = 1'b1;
                    end
                    else
                    begin
                        emit       = 1'b0;
                        phase_next = PH_LOW;
                        hn_next    = hv;
                    end
                end
                PH_LOW:
                begin
                    push_cmd.ch = {8'h00, hn_reg, hv};
                end
                default:
                begin
                    if (src_data.in_char == CHAR_PCT)
                    begin
                        if (src_data.in_last)
                        begin
                            push_cmd.ch = 16'h0000;
                        end
                        else
                        begin
                            emit       = 1'b0;
                            phase_next = PH_HIGH;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            hn_reg    <= 4'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                hn_reg    <= hn_next;
            end
        end
    end

endmodule

// ----- rtl/upc_queue.sv -----
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module upc_queue
    import upc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t q_stat
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == QCNT_W'(0));
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/upc_back.sv -----
// Back end: expands queued commands into output characters behind an output register.
`timescale 1ns / 1ps

module upc_back
    import upc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  q_status_t q_stat,
    output logic      pop,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_data
);

    localparam logic [1:0] ST_NEXT = 2'd0;
    localparam logic [1:0] ST_HI   = 2'd1;
    localparam logic [1:0] ST_LO   = 2'd2;

    logic       valid_reg;
    logic       valid_next;
    out_item_t  data_reg;
    out_item_t  data_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic       advance;

    assign advance   = !valid_reg || !dst_stall;
    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        pop        = 1'b0;
        if (advance)
        begin
            case (step_reg)
                ST_HI:
                begin
                    valid_next         = 1'b1;
                    data_next.out_char = hex_digit_char(cmd_reg.ch[7:4]);
                    data_next.out_last = 1'b0;
                    step_next          = ST_LO;
                end
                ST_LO:
                begin
                    valid_next         = 1'b1;
                    data_next.out_char = hex_digit_char(cmd_reg.ch[3:0]);
                    data_next.out_last = cmd_reg.last;
                    step_next          = ST_NEXT;
                end
                default:
                begin
                    step_next = ST_NEXT;
                    if (!q_stat.empty)
                    begin
                        pop        = 1'b1;
                        valid_next = 1'b1;
                        cmd_next   = head;
                        if (head.triple)
                        begin
                            data_next.out_char = CHAR_PCT;
                            data_next.out_last = 1'b0;
                            step_next          = ST_HI;
                        end
                        else
                        begin
                            data_next.out_char = head.ch;
                            data_next.out_last = head.last;
                        end
                    end
                    else
                    begin
                        valid_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        cmd_reg  <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= ST_NEXT;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- tb/sv/tb_url_percent_codec.sv -----
// Self-checking testbench for the URL percent codec: random-gap driver, predictor and monitor.
`timescale 1ns / 1ps

module tb_url_percent_codec;
    import upc_pkg::*;

    typedef enum logic [1:0] {ESC_IDLE, ESC_HIGH, ESC_LOW} esc_state_e;

    localparam int SETTLE_CYCLES = 6;

    logic      clk;
    logic      rst_n;
    logic      cfg_write;
    logic      cfg_data;
    logic      src_valid;
    logic      src_stall;
    in_item_t  src_data;
    logic      dst_valid;
    logic      dst_stall;
    out_item_t dst_data;

    in_item_t   string_chars_q[$];
    out_item_t  converted_q[$];

    logic       codec_mode;
    esc_state_e esc_state;
    logic [3:0] esc_high;

    bit src_taken;
    bit src_gaps;
    bit dst_gaps;
    int err_count;

    logic [15:0] reserved_chars [27] = '{
        16'h003C, 16'h003E, 16'h0023, 16'h0040, 16'h0022, 16'h0026, 16'h0025,
        16'h0024, 16'h003A, 16'h002C, 16'h003B, 16'h003F, 16'h003D, 16'h007B,
        16'h007D, 16'h007C, 16'h005E, 16'h007E, 16'h005B, 16'h005D, 16'h0027,
        16'h0060, 16'h005C, 16'h0020, 16'h000A, 16'h0009, 16'h000D
    };

    logic [15:0] hex_chars [22] = '{
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
        16'h0037, 16'h0038, 16'h0039, 16'h0041, 16'h0042, 16'h0043, 16'h0044,
        16'h0045, 16'h0046, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065,
        16'h0066
    };

    url_percent_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] digit_char(input logic [3:0] nib);
        if (nib > 4'd9)
        begin
            return {12'h000, nib} + 16'h0037;
        end
        return {12'h000, nib} + 16'h0030;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [15:0] ch);
        if (ch >= 16'h0041 && ch <= 16'h0046)
        begin
            return 4'(ch - 16'h0041 + 16'd10);
        end
        if (ch >= 16'h0061 && ch <= 16'h0066)
        begin
            return 4'(ch - 16'h0061 + 16'd10);
        end
        if (ch >= 16'h0030 && ch <= 16'h0039)
        begin
            return 4'(ch - 16'h0030);
        end
        return 4'd0;
    endfunction

    function automatic void convert_char(input in_item_t it);
        logic special;
        special = 1'b0;
        if (!codec_mode)
        begin
            esc_state = ESC_IDLE;
            esc_high = 4'd0;
            foreach (reserved_chars[k])
            begin
                if (reserved_chars[k] == it.in_char)
                begin
                    special = 1'b1;
                end
            end
            if (special)
            begin
                converted_q.push_back(out_item_t'{out_char: CHAR_PCT, out_last: 1'b0});
                converted_q.push_back(out_item_t'{out_char: digit_char(it.in_char[7:4]),
                                                  out_last: 1'b0});
                converted_q.push_back(out_item_t'{out_char: digit_char(it.in_char[3:0]),
                                                  out_last: it.in_last});
            end
            else
            begin
                converted_q.push_back(out_item_t'{out_char: it.in_char, out_last: it.in_last});
            end
        end
        else
        begin
            case (esc_state)
                ESC_HIGH:
                begin
                    if (it.in_last)
                    begin
                        converted_q.push_back(out_item_t'{
                            out_char: {8'h00, nibble_of(it.in_char), 4'h0}, out_last: 1'b1});
                        esc_state = ESC_IDLE;
                        esc_high = 4'd0;
                    end
                    else
                    begin
                        esc_high = nibble_of(it.in_char);
                        esc_state = ESC_LOW;
                    end
                end
                ESC_LOW:
                begin
                    converted_q.push_back(out_item_t'{
                        out_char: {8'h00, esc_high, nibble_of(it.in_char)},
                        out_last: it.in_last});
                    esc_state = ESC_IDLE;
                    esc_high = 4'd0;
                end
                default:
                begin
                    esc_state = ESC_IDLE;
                    esc_high = 4'd0;
                    if (it.in_char == CHAR_PCT)
                    begin
                        if (it.in_last)
                        begin
                            converted_q.push_back(out_item_t'{out_char: 16'h0000,
                                                              out_last: 1'b1});
                        end
                        else
                        begin
                            esc_state = ESC_HIGH;
                        end
                    end
                    else
                    begin
                        converted_q.push_back(out_item_t'{out_char: it.in_char,
                                                          out_last: it.in_last});
                    end
                end
            endcase
        end
    endfunction

    function automatic logic [15:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 30)
        begin
            return reserved_chars[$urandom_range(26)];
        end
        if (r < 50)
        begin
            return hex_chars[$urandom_range(21)];
        end
        if (r < 58)
        begin
            return CHAR_PCT;
        end
        if (r < 73)
        begin
            return 16'($urandom);
        end
        return 16'($urandom_range(16'h007E, 16'h0020));
    endfunction

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t: %s: expected char %h last %b, got char %h last %b",
                     $realtime, what, want.out_char, want.out_last,
                     got.out_char, got.out_last);
        end
    endtask

    always @(negedge clk)
    begin
        if (!src_valid || src_taken)
        begin
            if (string_chars_q.size() != 0 && !(src_gaps && $urandom_range(99) < 31))
            begin
                src_valid <= 1'b1;
                src_data <= string_chars_q.pop_front();
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
        dst_stall <= dst_gaps && ($urandom_range(99) < 31);
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        src_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                codec_mode = cfg_data;
            end
            if (dst_valid && !dst_stall)
            begin
                if (converted_q.size() == 0)
                begin
                    report_mismatch("unexpected transaction", '0, dst_data);
                end
                else
                begin
                    want = converted_q.pop_front();
                    if (dst_data.out_char !== want.out_char
                        || dst_data.out_last !== want.out_last)
                    begin
                        report_mismatch("mismatch", want, dst_data);
                    end
                end
            end
            if (src_valid && !src_stall)
            begin
                src_taken = 1'b1;
                convert_char(src_data);
            end
        end
    end

    task automatic push_char(input logic [15:0] ch, input logic last);
        string_chars_q.push_back(in_item_t'{in_char: ch, in_last: last});
    endtask

    task automatic settle();
        while (string_chars_q.size() != 0 || src_valid || converted_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_random(input bit decode_form, input int n);
        int added;
        int tokens;
        int r;
        in_item_t word[$];
        added = 0;
        while (added < n)
        begin
            word.delete();
            tokens = $urandom_range(6, 1);
            repeat (tokens)
            begin
                r = $urandom_range(99);
                if (decode_form && r < 45)
                begin
                    word.push_back(in_item_t'{in_char: CHAR_PCT, in_last: 1'b0});
                    word.push_back(in_item_t'{in_char: hex_chars[$urandom_range(21)],
                                              in_last: 1'b0});
                    word.push_back(in_item_t'{in_char: hex_chars[$urandom_range(21)],
                                              in_last: 1'b0});
                end
                else if (decode_form && r < 55)
                begin
                    word.push_back(in_item_t'{in_char: CHAR_PCT, in_last: 1'b0});
                    repeat ($urandom_range(2))
                    begin
                        word.push_back(in_item_t'{in_char: pick_char(), in_last: 1'b0});
                    end
                end
                else
                begin
                    word.push_back(in_item_t'{in_char: pick_char(), in_last: 1'b0});
                end
            end
            word[word.size() - 1].in_last = ($urandom_range(9) != 0);
            added += word.size();
            foreach (word[k])
            begin
                string_chars_q.push_back(word[k]);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        dst_stall = 1'b0;
        src_taken = 1'b0;
        src_gaps = 1'b1;
        dst_gaps = 1'b1;
        err_count = 0;
        codec_mode = 1'b0;
        esc_state = ESC_IDLE;
        esc_high = 4'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_char(16'h0041, 1'b0);
        push_char(16'h0000, 1'b0);
        push_char(16'hFFFF, 1'b1);
        push_char(CHAR_PCT, 1'b0);
        push_char(16'h0020, 1'b0);
        push_char(16'h000A, 1'b1);
        push_char(16'h007E, 1'b1);
        push_char(16'h007F, 1'b0);
        settle();

        set_mode(1'b1);
        push_char(CHAR_PCT, 1'b0);
        push_char(16'h0061, 1'b0);
        push_char(16'h0046, 1'b0);
        push_char(CHAR_PCT, 1'b0);
        push_char(16'h007A, 1'b0);
        push_char(16'h0047, 1'b1);
        push_char(CHAR_PCT, 1'b0);
        push_char(CHAR_PCT, 1'b0);
        push_char(16'h0034, 1'b0);
        push_char(CHAR_PCT, 1'b0);
        push_char(16'h0062, 1'b1);
        push_char(CHAR_PCT, 1'b1);
        push_char(16'hFFFF, 1'b1);
        push_char(CHAR_PCT, 1'b0);
        settle();

        set_mode(1'b0);
        push_char(16'h0078, 1'b1);
        settle();
        set_mode(1'b1);
        push_char(CHAR_PCT, 1'b0);
        settle();
        set_mode(1'b0);
        set_mode(1'b1);
        push_char(16'h0034, 1'b0);
        push_char(16'h0031, 1'b1);
        settle();

        queue_random(1'b1, 34);
        settle();
        set_mode(1'b0);
        queue_random(1'b0, 34);
        settle();

        src_gaps = 1'b0;
        dst_gaps = 1'b0;
        set_mode(1'b1);
        queue_random(1'b1, 36);
        settle();

        src_gaps = 1'b1;
        dst_gaps = 1'b1;
        set_mode(1'b0);
        queue_random(1'b0, 32);
        settle();

        if (converted_q.size() != 0)
        begin
            err_count++;
            $display("%0d expected transactions never arrived", converted_q.size());
        end
        if (err_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
